@@ hw/rtl/integer_to_ascii_radix_defines.svh @@
// ---------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// Property wrappers for the checker of this block.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// Property checked only while out of reset
`define ITOA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define ITOA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/itoa_pkg.sv @@
// ---------------------------------------------------------------------------
// itoa_pkg
// Widths, character codes, state encoding and helpers for the integer to
// ASCII converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    // Width of the converted value (low bits of the input beat)
    localparam int VALUE_BITS  = 64;
    localparam int IN_DATA_W   = 64;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 8;

    // Digit stack: at most one digit per value bit
    localparam int STACK_DEPTH = VALUE_BITS;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(VALUE_BITS);

    // Register port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_RADIX = 1'b0;   // word index, paddr[2]

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_READ = 5'b01000,
        S_LOAD = 5'b10000
    } t_state;

    // Divider status towards the controller
    typedef struct packed {
        logic done;        // quotient and remainder final
        logic quot_zero;   // quotient is zero, last digit made
    } t_div_status;

    // Clamp the programmed base into 2..36
    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) res = RADIX_MIN;
        if (r > RADIX_MAX) res = RADIX_MAX;
        return res;
    endfunction

    // Digit to ASCII, letters for ten and above
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = CHAR_W'(d);
        if (d < RADIX_DEC) return CH_ZERO + dw;
        return CH_LOWER_A + dw - CHAR_W'(RADIX_DEC);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/integer_to_ascii_radix.sv @@
// ---------------------------------------------------------------------------
// integer_to_ascii_radix
// Signed integer to ASCII text in a programmable base, one character a beat.
// ---------------------------------------------------------------------------
// One 64-bit signed value enters per input beat. Its text leaves as one
// character per output beat, most significant first, with tlast on the
// final one. The base comes from the radix register (2..36); values outside
// that range are clamped. Base ten prints a leading '-' for negative values,
// and other bases print the raw two's complement pattern. Digits come from a
// bit-serial divider that runs once per digit. Each digit character is then
// read back from the digit stack and loaded into the output register; a '-'
// is loaded directly. Output stalls lengthen the conversion. The next value
// is accepted once the last character sits in the output register. radix
// is at byte address 0 and should only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [itoa_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // [63:0] value
    // Output stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [itoa_pkg::CHAR_W-1:0]          m_axis_tdata,   // [7:0] text_char
    output logic                                 m_axis_tlast,   // last_char
    // Register port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [itoa_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [itoa_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [itoa_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import itoa_pkg::*;

    t_state                r_state, n_state;
    logic [RADIX_W-1:0]    r_radix;
    logic [RADIX_W-1:0]    r_base;
    logic                  r_neg;
    logic [COUNT_W-1:0]    r_count;
    logic [STACK_AW-1:0]   r_ptr, n_ptr;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_data, n_out_data;
    logic                  r_out_last, n_out_last;

    logic                  accept;
    logic                  out_free;
    logic [VALUE_BITS-1:0] pattern;
    logic [VALUE_BITS-1:0] magnitude;
    logic [RADIX_W-1:0]    base_in;
    logic                  neg_in;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [RADIX_W-1:0]    div_remainder;
    t_div_status           div_status;

    logic                  stk_wr_en;
    logic                  stk_rd_en;
    logic [RADIX_W-1:0]    stk_rd_data;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIX) ? APB_DATA_W'(r_radix) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIX) begin
            r_radix <= pwdata[RADIX_W-1:0];
        end
    end

    // Input beat: sign handling in base ten only
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pattern       = s_axis_tdata[VALUE_BITS-1:0];
    assign base_in       = effective_radix(r_radix);
    assign neg_in        = (base_in == RADIX_DEC) && pattern[VALUE_BITS-1];
    assign magnitude     = neg_in ? (~pattern + 1'b1) : pattern;

    // Restart the divider on the quotient until it reaches zero
    assign stk_wr_en    = (r_state == S_DIV) && div_status.done;
    assign div_start    = accept || (stk_wr_en && !div_status.quot_zero);
    assign div_dividend = accept ? magnitude : div_quotient;
    assign stk_rd_en    = (r_state == S_READ);
    assign out_free     = !r_out_valid || m_axis_tready;

    itoa_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_radix     (r_base),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder),
        .o_status    (div_status)
    );

    itoa_digit_stack u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (r_count[STACK_AW-1:0]),
        .i_wr_data (div_remainder),
        .i_rd_en   (stk_rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (stk_rd_data)
    );

    // Sequencer: divide, then sign, then digits top of stack first
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_status.done && div_status.quot_zero) begin
                    n_ptr   = r_count[STACK_AW-1:0];
                    n_state = r_neg ? S_SIGN : S_READ;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = digit_char(stk_rd_data);
                    n_out_last  = (r_ptr == '0);
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_count <= '0;
                r_neg   <= neg_in;
            end else if (stk_wr_en) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) r_base <= base_in;
        r_ptr      <= n_ptr;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ hw/rtl/itoa_divider.sv @@
// ---------------------------------------------------------------------------
// itoa_divider
// Bit-serial restoring divider: one quotient bit per cycle, remainder kept
// below the base.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_divider (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire  [itoa_pkg::VALUE_BITS-1:0]       i_dividend,
    input  wire  [itoa_pkg::RADIX_W-1:0]          i_radix,
    output logic [itoa_pkg::VALUE_BITS-1:0]       o_quotient,
    output logic [itoa_pkg::RADIX_W-1:0]          o_remainder,
    output itoa_pkg::t_div_status                 o_status
);
    import itoa_pkg::*;

    logic [VALUE_BITS-1:0] r_quo;
    logic [RADIX_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [RADIX_W:0]      trial;
    logic                  fits;
    logic [RADIX_W:0]      diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_quo[VALUE_BITS-1]};
        fits  = (trial >= {1'b0, i_radix});
        diff  = trial - {1'b0, i_radix};
    end

    // Control: count the bit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(VALUE_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts in from the right, remainder restores
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], fits};
            r_rem <= fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
        end
    end

    assign o_quotient         = r_quo;
    assign o_remainder        = r_rem;
    assign o_status.done      = r_done;
    assign o_status.quot_zero = (r_quo == '0);

endmodule

`default_nettype wire

@@ hw/rtl/itoa_digit_stack.sv @@
// ---------------------------------------------------------------------------
// itoa_digit_stack
// Digit store, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_digit_stack (
    input  wire                                 i_clk,
    input  wire                                 i_wr_en,
    input  wire  [itoa_pkg::STACK_AW-1:0]       i_wr_addr,
    input  wire  [itoa_pkg::RADIX_W-1:0]        i_wr_data,
    input  wire                                 i_rd_en,
    input  wire  [itoa_pkg::STACK_AW-1:0]       i_rd_addr,
    output logic [itoa_pkg::RADIX_W-1:0]        o_rd_data
);
    import itoa_pkg::*;

    logic [RADIX_W-1:0] r_mem [STACK_DEPTH];
    logic [RADIX_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/itoa_checker.sv @@
// ---------------------------------------------------------------------------
// itoa_checker
// Port-level checks on the integer to ASCII converter, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_radix_defines.svh"

module itoa_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [itoa_pkg::CHAR_W-1:0]         m_axis_tdata,
    input wire                                m_axis_tlast
);
    import itoa_pkg::*;

    // Stalled output beat holds
    `ITOA_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed under stall")

    // One value in flight: input closes after a beat
    `ITOA_ASSERT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second value taken while converting")

    // Only sign, digits and lower-case letters leave the block
    `ITOA_ASSERT(a_char_set, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata == CH_MINUS) || (m_axis_tdata >= CH_ZERO && m_axis_tdata <= 8'h39) || (m_axis_tdata >= CH_LOWER_A && m_axis_tdata <= 8'h7A), "character outside the digit set")

    // Reset leaves no beat pending
    `ITOA_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "output not cleared by reset")

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
